FILE: hw/rtl/pas_pkg.sv
`default_nettype none

package pas_pkg;

  // sizing defaults
  localparam int DEGREES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // coefficient limit after reset
  localparam logic [9:0] LIMIT_RESET = 10'd999;

  // input function codes
  localparam logic [2:0] FN_LOAD_A = 3'd0;
  localparam logic [2:0] FN_LOAD_B = 3'd1;
  localparam logic [2:0] FN_ADD    = 3'd2;
  localparam logic [2:0] FN_SUB    = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_TERM     = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_REJECT = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [5:0]         degree;
    logic signed [10:0] coef;
  } op_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/polynomial_add_subtract.sv
// polynomial add / subtract unit
// input: a word is taken at a clock edge with start high and busy low. in_func picks
//   load into store A, load into store B, emit A+B, emit A-B or clear both stores;
//   in_degree and in_coefficient carry the term for loads. unused func codes are
//   taken and dropped without any result
// config: cfg_wr_en writes cfg_coef_limit, the magnitude limit for loads and sums;
//   write it only while the unit is idle
// output: each result word shows for one cycle with out_valid high; the receiver
//   cannot hold it off, so the unit never waits on the output side
// sequence: a load, clear or rejected load passes through the queue and gives its one
//   result from the output register when the back end is idle. an add or subtract
//   walks degrees from the top down, one degree per cycle through the registered store
//   read; the tail state gives the last word when degree 0 and a higher degree both
//   give terms, and overflow ends the walk early; the walk's last word carries out_last
// throughput: the back end runs one word at a time; a 2-entry queue behind the
//   classifier keeps busy low so that up to two more words can be taken during a walk
// reset: synchronous, active low; both stores read as zero through per-degree valid
//   bits cleared at once, the limit returns to 999, the queue empties and no result
//   is shown in the cycle after reset
`default_nettype none

module polynomial_add_subtract #(
  parameter int DEGREES     = pas_pkg::DEGREES_DEF,
  parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_func,
  input  wire logic [5:0]         in_degree,
  input  wire logic signed [10:0] in_coefficient,
  // result channel
  output logic                    out_valid,
  output logic [5:0]              out_term_degree,
  output logic signed [10:0]      out_term_coefficient,
  output logic [2:0]              out_status,
  output logic                    out_last,
  // limit register
  input  wire logic               cfg_wr_en,
  input  wire logic [9:0]         cfg_coef_limit
);

  pas_pkg::q_stat_t q_stat;
  pas_pkg::op_t     push_op;
  pas_pkg::op_t     head;
  logic             push;
  logic             pop;
  logic [9:0]       limit;

  // front: accepts words, holds the limit, range-checks loads
  pas_front #(
    .DEGREES (DEGREES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_func        (in_func),
    .in_degree      (in_degree),
    .in_coefficient (in_coefficient),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_coef_limit (cfg_coef_limit),
    .q_stat         (q_stat),
    .busy           (busy),
    .push           (push),
    .push_op        (push_op),
    .limit          (limit)
  );

  // queue of classified operations between front and back
  pas_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // back: stores, degree walk and result register
  pas_back #(
    .DEGREES (DEGREES)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_stat               (q_stat),
    .limit                (limit),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_term_degree      (out_term_degree),
    .out_term_coefficient (out_term_coefficient),
    .out_status           (out_status),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pas_front.sv
`default_nettype none

module pas_front #(
  parameter int DEGREES = pas_pkg::DEGREES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [2:0]         in_func,
  input  wire logic [5:0]         in_degree,
  input  wire logic signed [10:0] in_coefficient,
  input  wire logic               cfg_wr_en,
  input  wire logic [9:0]         cfg_coef_limit,
  input  wire pas_pkg::q_stat_t   q_stat,
  output logic                    busy,
  output logic                    push,
  output pas_pkg::op_t            push_op,
  output logic [9:0]              limit
);

  logic [9:0]  limit_r;
  logic [11:0] neg;
  logic [10:0] mag;
  logic        bad;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pas_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_coef_limit;
    end
  end

  assign limit  = limit_r;
  assign busy   = q_stat.full;
  assign accept = start && !q_stat.full;

  // magnitude of the loaded coefficient, -1024 included
  assign neg = 12'd0 - {in_coefficient[10], in_coefficient};
  assign mag = in_coefficient[10] ? neg[10:0] : in_coefficient;
  assign bad = ({1'b0, in_degree} >= 7'(DEGREES)) || (mag > {1'b0, limit_r});

  always_comb begin
    push_op.degree = in_degree;
    push_op.coef   = in_coefficient;
    push_op.kind   = pas_pkg::OP_REJECT;
    push           = 1'b0;
    case (in_func)
      pas_pkg::FN_LOAD_A: begin
        push         = accept;
        push_op.kind = bad ? pas_pkg::OP_REJECT : pas_pkg::OP_LOAD_A;
      end
      pas_pkg::FN_LOAD_B: begin
        push         = accept;
        push_op.kind = bad ? pas_pkg::OP_REJECT : pas_pkg::OP_LOAD_B;
      end
      pas_pkg::FN_ADD: begin
        push         = accept;
        push_op.kind = pas_pkg::OP_ADD;
      end
      pas_pkg::FN_SUB: begin
        push         = accept;
        push_op.kind = pas_pkg::OP_SUB;
      end
      pas_pkg::FN_CLEAR: begin
        push         = accept;
        push_op.kind = pas_pkg::OP_CLEAR;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pas_fifo.sv
`default_nettype none

module pas_fifo #(
  parameter int DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire pas_pkg::op_t     push_op,
  input  wire logic             pop,
  output pas_pkg::op_t          head,
  output pas_pkg::q_stat_t      q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pas_pkg::op_t  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pas_back.sv
`default_nettype none

module pas_back #(
  parameter int DEGREES = pas_pkg::DEGREES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pas_pkg::op_t       head,
  input  wire pas_pkg::q_stat_t   q_stat,
  input  wire logic [9:0]         limit,
  output logic                    pop,
  output logic                    out_valid,
  output logic [5:0]              out_term_degree,
  output logic signed [10:0]      out_term_coefficient,
  output logic [2:0]              out_status,
  output logic                    out_last
);

  localparam int AW = $clog2(DEGREES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_TAIL = 4'b0100,
    S_OVF  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // coefficient stores, valid bits stand in for the zero reset
  logic signed [10:0] mem_a [DEGREES];
  logic signed [10:0] mem_b [DEGREES];
  logic [DEGREES-1:0] vld_a_r, vld_a_nxt;
  logic [DEGREES-1:0] vld_b_r, vld_b_nxt;
  logic               we_a, we_b;
  logic [AW-1:0]      waddr;

  // walk control
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               iss_r, iss_nxt;
  logic               rd_en;
  logic               sub_r, sub_nxt;
  logic               s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]      s1_deg_r, s1_deg_nxt;
  logic               s1_end_r, s1_end_nxt;
  logic signed [10:0] rd_a_r, rd_b_r;
  logic               rdv_a_r, rdv_b_r;

  // held term waiting to learn whether it is the last one
  logic               pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]      pend_deg_r, pend_deg_nxt;
  logic signed [10:0] pend_coef_r, pend_coef_nxt;
  logic [AW-1:0]      ovf_deg_r, ovf_deg_nxt;

  // sum stage
  logic signed [11:0] a_ext, b_ext, sum;
  logic [11:0]        sum_mag;
  logic               ovf, nonzero;

  // result before the output register
  logic               res_vld;
  logic [5:0]         res_deg;
  logic signed [10:0] res_coef;
  logic [2:0]         res_status;
  logic               res_last;

  logic               out_valid_r;
  logic [5:0]         out_deg_r;
  logic signed [10:0] out_coef_r;
  logic [2:0]         out_status_r;
  logic               out_last_r;

  assign a_ext   = rdv_a_r ? {rd_a_r[10], rd_a_r} : 12'sd0;
  assign b_ext   = rdv_b_r ? {rd_b_r[10], rd_b_r} : 12'sd0;
  assign sum     = sub_r ? (a_ext - b_ext) : (a_ext + b_ext);
  assign sum_mag = sum[11] ? (12'd0 - sum) : sum;
  assign ovf     = sum_mag > {2'b00, limit};
  assign nonzero = (sum != 12'sd0);

  assign pop = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt     = state_r;
    vld_a_nxt     = vld_a_r;
    vld_b_nxt     = vld_b_r;
    we_a          = 1'b0;
    we_b          = 1'b0;
    waddr         = head.degree[AW-1:0];
    addr_nxt      = addr_r;
    iss_nxt       = iss_r;
    rd_en         = 1'b0;
    sub_nxt       = sub_r;
    s1_vld_nxt    = 1'b0;
    s1_deg_nxt    = s1_deg_r;
    s1_end_nxt    = s1_end_r;
    pend_vld_nxt  = pend_vld_r;
    pend_deg_nxt  = pend_deg_r;
    pend_coef_nxt = pend_coef_r;
    ovf_deg_nxt   = ovf_deg_r;
    res_vld       = 1'b0;
    res_deg       = '0;
    res_coef      = '0;
    res_status    = pas_pkg::ST_TERM;
    res_last      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          case (head.kind)
            pas_pkg::OP_LOAD_A: begin
              we_a             = 1'b1;
              vld_a_nxt[waddr] = 1'b1;
              res_vld          = 1'b1;
              res_status       = pas_pkg::ST_ACCEPT;
              res_last         = 1'b1;
            end
            pas_pkg::OP_LOAD_B: begin
              we_b             = 1'b1;
              vld_b_nxt[waddr] = 1'b1;
              res_vld          = 1'b1;
              res_status       = pas_pkg::ST_ACCEPT;
              res_last         = 1'b1;
            end
            pas_pkg::OP_CLEAR: begin
              vld_a_nxt  = '0;
              vld_b_nxt  = '0;
              res_vld    = 1'b1;
              res_status = pas_pkg::ST_ACCEPT;
              res_last   = 1'b1;
            end
            pas_pkg::OP_REJECT: begin
              res_vld    = 1'b1;
              res_status = pas_pkg::ST_REJECT;
              res_last   = 1'b1;
            end
            pas_pkg::OP_ADD, pas_pkg::OP_SUB: begin
              sub_nxt      = (head.kind == pas_pkg::OP_SUB);
              addr_nxt     = AW'(DEGREES - 1);
              iss_nxt      = 1'b1;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_WALK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        // read side: one degree per cycle, highest first
        if (iss_r) begin
          rd_en      = 1'b1;
          s1_vld_nxt = 1'b1;
          s1_deg_nxt = addr_r;
          s1_end_nxt = (addr_r == '0);
          if (addr_r == '0) begin
            iss_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r - 1'b1;
          end
        end
        // sum side
        if (s1_vld_r) begin
          if (ovf) begin
            iss_nxt    = 1'b0;
            s1_vld_nxt = 1'b0;
            if (pend_vld_r) begin
              res_vld     = 1'b1;
              res_deg     = 6'(pend_deg_r);
              res_coef    = pend_coef_r;
              ovf_deg_nxt = s1_deg_r;
              state_nxt   = S_OVF;
            end else begin
              res_vld    = 1'b1;
              res_deg    = 6'(s1_deg_r);
              res_status = pas_pkg::ST_OVERFLOW;
              res_last   = 1'b1;
              state_nxt  = S_IDLE;
            end
          end else if (nonzero) begin
            if (pend_vld_r) begin
              res_vld  = 1'b1;
              res_deg  = 6'(pend_deg_r);
              res_coef = pend_coef_r;
            end
            if (s1_end_r && !pend_vld_r) begin
              res_vld   = 1'b1;
              res_deg   = 6'(s1_deg_r);
              res_coef  = sum[10:0];
              res_last  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              pend_vld_nxt  = 1'b1;
              pend_deg_nxt  = s1_deg_r;
              pend_coef_nxt = sum[10:0];
              if (s1_end_r) begin
                state_nxt = S_TAIL;
              end
            end
          end else if (s1_end_r) begin
            res_vld   = 1'b1;
            res_last  = 1'b1;
            state_nxt = S_IDLE;
            if (pend_vld_r) begin
              res_deg  = 6'(pend_deg_r);
              res_coef = pend_coef_r;
            end else begin
              res_status = pas_pkg::ST_EMPTY;
            end
          end
        end
      end

      S_TAIL: begin
        res_vld      = 1'b1;
        res_deg      = 6'(pend_deg_r);
        res_coef     = pend_coef_r;
        res_last     = 1'b1;
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      S_OVF: begin
        res_vld      = 1'b1;
        res_deg      = 6'(ovf_deg_r);
        res_status   = pas_pkg::ST_OVERFLOW;
        res_last     = 1'b1;
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_a_r     <= '0;
      vld_b_r     <= '0;
      iss_r       <= 1'b0;
      s1_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_a_r     <= vld_a_nxt;
      vld_b_r     <= vld_b_nxt;
      iss_r       <= iss_nxt;
      s1_vld_r    <= s1_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    sub_r        <= sub_nxt;
    s1_deg_r     <= s1_deg_nxt;
    s1_end_r     <= s1_end_nxt;
    pend_deg_r   <= pend_deg_nxt;
    pend_coef_r  <= pend_coef_nxt;
    ovf_deg_r    <= ovf_deg_nxt;
    out_deg_r    <= res_deg;
    out_coef_r   <= res_coef;
    out_status_r <= res_status;
    out_last_r   <= res_last;
  end

  // store ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= head.coef;
    end
    if (rd_en) begin
      rd_a_r <= mem_a[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= head.coef;
    end
    if (rd_en) begin
      rd_b_r <= mem_b[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdv_a_r <= vld_a_r[addr_r];
      rdv_b_r <= vld_b_r[addr_r];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_term_degree      = out_deg_r;
  assign out_term_coefficient = out_coef_r;
  assign out_status           = out_status_r;
  assign out_last             = out_last_r;

endmodule

`default_nettype wire
